FILE: sv/assert_macros.svh
// Assertion macros shared by the priority queue RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BSPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BSPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/bspq_pkg.sv
// Types and constants of the bounded sorted priority queue.
// Used by bspq_cell and bounded_sorted_priority_queue_unit; depends on nothing.
package bspq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int PRIO_W     = 8;
   localparam int CLIENT_W   = 16;
   localparam int DELAY_W    = 16;
   localparam int REQUEST_W  = 32;
   localparam int CAP_W      = 5;
   localparam int OCC_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOWEST_PRIORITY  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HIGHEST_PRIORITY = 2'd2;

   localparam logic [CAP_W-1:0]  CAPACITY_RESET = 5'd16;
   localparam logic [PRIO_W-1:0] LOWEST_RESET   = 8'd0;
   localparam logic [PRIO_W-1:0] HIGHEST_RESET  = 8'd255;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic [PRIO_W-1:0]    prio;
      logic [CLIENT_W-1:0]  client;
      logic [DELAY_W-1:0]   delay;
      logic [REQUEST_W-1:0] request;
   } entry_type;

   // Per-cell control: the operation of this cycle and what the cell
   // needs to know about its place in the sorted row.
   typedef struct packed {
      logic insert;
      logic pop;
      logic occupied;
      logic left_keep;
   } cell_ctrl_type;

endpackage

FILE: sv/bspq_cell.sv
// One slot of the sorted row: holds an entry and shifts it left or right.
// Depends on bspq_pkg.
module bspq_cell (
   input  logic                   clock,
   input  bspq_pkg::cell_ctrl_type ctrl,
   input  bspq_pkg::entry_type    new_entry,
   input  bspq_pkg::entry_type    left_entry,
   input  bspq_pkg::entry_type    right_entry,
   output bspq_pkg::entry_type    entry,
   output logic                   keep
);

   bspq_pkg::entry_type entry_ff;
   bspq_pkg::entry_type entry_in;

   // An occupied entry of equal or higher priority stays ahead of the new one.
   assign keep  = ctrl.occupied && (entry_ff.prio >= new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (ctrl.left_keep) begin
            entry_in = new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: sv/bounded_sorted_priority_queue_unit.sv
// Top level of the bounded sorted priority queue: configuration registers,
// occupancy counter, the row of bspq_cell slots and the result register.
// Depends on bspq_pkg, bspq_cell and assert_macros.svh.
`include "assert_macros.svh"

// The queue takes one item, an insert or a pop, in every clock cycle: busy
// stays low, so an item is accepted at every edge where start is high. Its
// result appears on the rsp_ ports for exactly one cycle, marked by
// rsp_strobe, in the cycle right after acceptance; there is no back-pressure,
// so the receiver must take it then. In the slot row every slot compares its
// priority with the incoming one in parallel and moves to its neighbor's
// place in the same edge. Entries are kept sorted by descending priority,
// ties in arrival order, and a pop always returns slot zero. An insert is
// refused as full when the occupancy has reached the smaller of the capacity
// register and DEPTH, checked before the priority range. Slots hold no reset
// value and nothing needs clearing after reset; only occupied slots are ever
// returned. The data fields of every result other than a successful pop read
// zero. The rsp_occupancy port shows the low five bits of the count.
// Configuration registers may be written only while no item is in flight.
module bounded_sorted_priority_queue_unit #(
   parameter int DEPTH = bspq_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_cmd,
   input  logic [bspq_pkg::PRIO_W-1:0]          req_entry_priority,
   input  logic [bspq_pkg::CLIENT_W-1:0]        req_entry_client,
   input  logic [bspq_pkg::DELAY_W-1:0]         req_entry_delay,
   input  logic [bspq_pkg::REQUEST_W-1:0]       req_entry_request,
   output logic                                 rsp_strobe,
   output logic [1:0]                           rsp_status,
   output logic [bspq_pkg::PRIO_W-1:0]          rsp_out_priority,
   output logic [bspq_pkg::CLIENT_W-1:0]        rsp_out_client,
   output logic [bspq_pkg::DELAY_W-1:0]         rsp_out_delay,
   output logic [bspq_pkg::REQUEST_W-1:0]       rsp_out_request,
   output logic [bspq_pkg::OCC_W-1:0]           rsp_occupancy,
   input  logic                                 csr_write_enable,
   input  logic [bspq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bspq_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   // The count must hold DEPTH itself; the limit compare is done at a width
   // that fits both the count and the capacity register.
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int LIM_W = (CNT_W > bspq_pkg::CAP_W) ? CNT_W : bspq_pkg::CAP_W;

   // Configuration registers.
   logic [bspq_pkg::CAP_W-1:0]  capacity_ff;
   logic [bspq_pkg::PRIO_W-1:0] lowest_ff;
   logic [bspq_pkg::PRIO_W-1:0] highest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= bspq_pkg::CAPACITY_RESET;
         lowest_ff   <= bspq_pkg::LOWEST_RESET;
         highest_ff  <= bspq_pkg::HIGHEST_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            bspq_pkg::REG_CAPACITY: begin
               capacity_ff <= csr_write_data[bspq_pkg::CAP_W-1:0];
            end
            bspq_pkg::REG_LOWEST_PRIORITY: begin
               lowest_ff <= csr_write_data;
            end
            bspq_pkg::REG_HIGHEST_PRIORITY: begin
               highest_ff <= csr_write_data;
            end
            default: begin
               // Indexes beyond the register list are dropped.
            end
         endcase
      end
   end

   // Decode of the incoming item.
   logic                accept;
   logic                is_pop;
   logic                full;
   logic                in_range;
   logic                do_insert;
   logic                do_pop;
   logic [LIM_W-1:0]    limit;
   logic [LIM_W-1:0]    count_ext;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   bspq_pkg::entry_type new_entry;
   bspq_pkg::status_type status_next;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign is_pop    = (req_cmd == bspq_pkg::CMD_POP);

   // The usable limit is the capacity register saturated at DEPTH.
   assign limit     = (LIM_W'(capacity_ff) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH)
                                                            : LIM_W'(capacity_ff);
   assign count_ext = LIM_W'(count_ff);
   assign full      = (count_ext >= limit);
   assign in_range  = (req_entry_priority >= lowest_ff) &&
                      (req_entry_priority <= highest_ff);

   assign do_insert = accept && !is_pop && !full && in_range;
   assign do_pop    = accept && is_pop && (count_ff != '0);

   assign new_entry.prio    = req_entry_priority;
   assign new_entry.client  = req_entry_client;
   assign new_entry.delay   = req_entry_delay;
   assign new_entry.request = req_entry_request;

   always_comb begin
      if (is_pop) begin
         status_next = (count_ff == '0) ? bspq_pkg::STATUS_EMPTY : bspq_pkg::STATUS_OK;
      end else if (full) begin
         status_next = bspq_pkg::STATUS_FULL;
      end else if (!in_range) begin
         status_next = bspq_pkg::STATUS_RANGE;
      end else begin
         status_next = bspq_pkg::STATUS_OK;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // The row of slots. Slot zero is the head. Each slot reports whether it
   // keeps its place on an insert; the first slot that does not takes the
   // new entry and every later slot takes its left neighbor. On a pop every
   // slot takes its right neighbor.
   bspq_pkg::entry_type slot_entry [DEPTH];
   logic [DEPTH-1:0]    slot_keep;

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_slot
      bspq_pkg::cell_ctrl_type ctrl;
      bspq_pkg::entry_type     left_entry;
      bspq_pkg::entry_type     right_entry;

      assign ctrl.insert   = do_insert;
      assign ctrl.pop      = do_pop;
      assign ctrl.occupied = (LIM_W'(gi) < count_ext);

      if (gi == 0) begin : g_head
         assign ctrl.left_keep = 1'b1;
         assign left_entry     = new_entry;
      end else begin : g_body
         assign ctrl.left_keep = slot_keep[gi-1];
         assign left_entry     = slot_entry[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
         // The last slot falls outside the count after a pop.
         assign right_entry = new_entry;
      end else begin : g_inner
         assign right_entry = slot_entry[gi+1];
      end

      bspq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (slot_entry[gi]),
         .keep        (slot_keep[gi])
      );
   end

   // Result register: one item per accepted request, in the following cycle.
   logic                  strobe_ff;
   bspq_pkg::status_type  status_ff;
   bspq_pkg::entry_type   out_ff;
   bspq_pkg::entry_type   out_in;
   logic [CNT_W-1:0]      occ_ff;

   assign out_in = do_pop ? slot_entry[0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_next;
         out_ff    <= out_in;
         occ_ff    <= count_in;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_priority = out_ff.prio;
   assign rsp_out_client   = out_ff.client;
   assign rsp_out_delay    = out_ff.delay;
   assign rsp_out_request  = out_ff.request;
   assign rsp_occupancy    = bspq_pkg::OCC_W'(occ_ff);

   // The count never runs past the built depth.
   `BSPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, LIM_W'(count_ff) <= LIM_W'(DEPTH))
   // Every accepted item yields a result in the next cycle, and nothing else does.
   `BSPQ_ASSERT_NEXT(a_one_result, clock, reset, 1'b1, rsp_strobe == $past(accept))
   // A pop on an empty queue reports empty and leaves the count at zero.
   `BSPQ_ASSERT_NEXT(a_pop_empty, clock, reset, accept && is_pop && (count_ff == '0),
      (rsp_status == bspq_pkg::STATUS_EMPTY) && (count_ff == '0))
   // A successful insert grows the count by one and reports status OK.
   `BSPQ_ASSERT_NEXT(a_insert_count, clock, reset, do_insert,
      (count_ff == $past(count_ff) + CNT_W'(1)) && (rsp_status == bspq_pkg::STATUS_OK))

endmodule
